>>> rtl/ssfd_pkg.sv
// shared constants and helpers for the stiff string finite-difference step unit
package ssfd_pkg;

  // default string storage depth
  localparam int MAX_POINTS_DEF = 256;

  // data widths
  localparam int VAL_W    = 23;  // Q2.20 displacement and velocity
  localparam int SAMPLE_W = 24;  // pickup sum
  localparam int ACC_W    = 32;  // working accumulator
  localparam int COEF_W   = 19;  // unsigned coefficient operand
  localparam int PROD_W   = ACC_W + COEF_W + 1;
  localparam int Q_SHIFT  = 18;
  localparam int LOSS_W   = 12;

  // coefficient and value limits
  localparam int ONE_Q18   = 262144;
  localparam int VAL_LIM   = 2097152;
  localparam int N_MIN     = 16;
  localparam int STEPS_MAX = 16;
  localparam int RATE_MIN  = 2621;
  localparam int RATE_MAX  = 183501;
  localparam int STIFF_MAX = 65536;
  localparam int DAMP_MAX  = 262144;
  localparam int PALM_MAX  = 3146;

  // palm window half width n/10 as a reciprocal multiply, exact for n up to 1024
  localparam int W_RECIP    = 6554;
  localparam int W_RECIP_SH = 16;

  // register reset values
  localparam logic [8:0]  RST_NUM_POINTS  = 9'd16;
  localparam logic [4:0]  RST_SUB_STEPS   = 5'd1;
  localparam logic [17:0] RST_PITCH_RATE  = 18'd2621;
  localparam logic [16:0] RST_STIFFNESS   = 17'd0;
  localparam logic [18:0] RST_DAMPING     = 19'd262144;
  localparam logic [7:0]  RST_PALM_CENTER = 8'd1;
  localparam logic [11:0] RST_PALM_LOSS   = 12'd0;
  localparam logic [35:0] RST_BRIDGE      = 36'hF_FFFF_FFFF;

  // transaction modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // register indexes
  localparam logic [2:0] REG_NUM_POINTS  = 3'd0;
  localparam logic [2:0] REG_SUB_STEPS   = 3'd1;
  localparam logic [2:0] REG_PITCH_RATE  = 3'd2;
  localparam logic [2:0] REG_STIFFNESS   = 3'd3;
  localparam logic [2:0] REG_DAMPING     = 3'd4;
  localparam logic [2:0] REG_PALM_CENTER = 3'd5;
  localparam logic [2:0] REG_PALM_LOSS   = 3'd6;
  localparam logic [2:0] REG_BRIDGE      = 3'd7;

  // clamp a working value to the Q2.20 store range
  function automatic logic signed [VAL_W-1:0] clamp_val(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] lim;
    lim = ACC_W'(VAL_LIM);
    if (v > lim) begin
      clamp_val = VAL_W'(lim);
    end else if (v < -lim) begin
      clamp_val = VAL_W'(-lim);
    end else begin
      clamp_val = VAL_W'(v);
    end
  endfunction

endpackage

>>> rtl/stiff_string_fd_step_unit.sv
// stiff string finite-difference step unit: top level with sequencer and shared multiplier
//
// Usage: an APB-style port sets the string registers (64-bit data, register i at 8*i).
// Input transactions carry mode, point_index, point_value and pickup_point. A write
// transaction loads one displacement point, a clear transaction zeroes both stores,
// and a tick transaction runs the string update sub_steps times (saturated to 1 up
// to STEPS_MAX) and returns one sample transaction.
// Every update is walked point by point through one shared 32x20 multiplier with
// a registered product; a bridge point takes one more multiply, and a point inside
// the palm window takes a loss multiply, a restoring divider (one bit per cycle)
// and a palm multiply.
// Each store takes one read and one write a cycle; the multiplier sequence sets the point rate.
// in_stall stays high while a tick or clear is in progress.
// After reset the block sweeps both stores to zero with in_stall high; register
// writes are taken during that sweep.
// The result sits in an output register; when the receiver stalls, the sample holds
// and the next tick transaction can be accepted, waiting at its end only if the
// previous sample has not yet been taken.
module stiff_string_fd_step_unit #(
  parameter int MAX_POINTS = ssfd_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [5:0]                          paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic [7:0]                          point_index,
  input  logic signed [ssfd_pkg::VAL_W-1:0]   point_value,
  input  logic [7:0]                          pickup_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ssfd_pkg::SAMPLE_W-1:0] sample
);

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int XW   = NW + 1;
  localparam int WW   = $clog2(MAX_POINTS / 10 + 1);
  localparam int DW   = WW + 1;
  localparam int NUMW = ssfd_pkg::LOSS_W + WW + 2;
  localparam int DCW  = $clog2(NUMW + 1);
  localparam int VW   = ssfd_pkg::VAL_W;
  localparam int AW   = ssfd_pkg::ACC_W;
  localparam int PW   = ssfd_pkg::PROD_W;
  localparam int CW   = ssfd_pkg::COEF_W;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (ssfd_pkg::Q_SHIFT - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_PRE, ST_LOAD, ST_M_STIFF, ST_A_STIFF, ST_M_RATE_F,
    ST_A_RATE_F, ST_M_DAMP, ST_A_DAMP, ST_M_RATE_V, ST_A_RATE_V, ST_M_LOSS,
    ST_D_INIT, ST_DIV, ST_M_PALM, ST_A_PALM, ST_M_BRIDGE, ST_A_BRIDGE,
    ST_WRITE, ST_ENDS, ST_PICK, ST_OUT
  } state_t;

  // configuration registers
  logic [8:0]  num_points;
  logic [4:0]  sub_steps;
  logic [17:0] pitch_rate;
  logic [16:0] stiffness_coef;
  logic [18:0] damping_coef;
  logic [7:0]  palm_center;
  logic [11:0] palm_loss;
  logic [35:0] bridge_losses;

  // sequencer state
  state_t state;
  logic [NW-1:0] cnt;
  logic [XW-1:0] i_idx;
  logic [4:0]    step;
  logic [7:0]    pick;
  logic signed [VW-1:0] wp [5];
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] pnew;
  logic signed [PW-1:0] prod;
  logic signed [AW+1:0] sum;
  logic [NUMW-1:0] dnum;
  logic [DW-1:0]   drem;
  logic [DCW-1:0]  dcnt;

  // stores
  logic signed [VW-1:0] pos_mem [MAX_POINTS];
  logic signed [VW-1:0] vel_mem [MAX_POINTS];
  logic                 pos_we, pos_re, vel_we, vel_re;
  logic [IW-1:0]        pos_waddr, pos_raddr, vel_waddr, vel_raddr;
  logic signed [VW-1:0] pos_wdata, vel_wdata, pos_rd, vel_rd;

  // derived controls
  logic [NW-1:0]  n_eff;
  logic [4:0]     steps;
  logic [17:0]    rate;
  logic [16:0]    stiff;
  logic [18:0]    damp;
  logic [11:0]    loss_pk;
  logic [WW-1:0]  w_len;
  logic [XW-1:0]  n_m2, n_m3, palm_c, pick_c, pt_dist;
  logic           in_palm, bend_on, br_edge, br_inner, br_hit, wr_ok;
  logic signed [AW-1:0] tension, bend, prod_rnd, mul_a;
  logic signed [PW-1:0] prod_sum;
  logic [CW-1:0]  mul_b;
  logic [DW:0]    trial;
  logic [DW-1:0]  den, rem_next;
  logic           q_bit;

  assign pready   = 1'b1;
  assign in_stall = (state != ST_IDLE);

  // register write port
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points     <= ssfd_pkg::RST_NUM_POINTS;
      sub_steps      <= ssfd_pkg::RST_SUB_STEPS;
      pitch_rate     <= ssfd_pkg::RST_PITCH_RATE;
      stiffness_coef <= ssfd_pkg::RST_STIFFNESS;
      damping_coef   <= ssfd_pkg::RST_DAMPING;
      palm_center    <= ssfd_pkg::RST_PALM_CENTER;
      palm_loss      <= ssfd_pkg::RST_PALM_LOSS;
      bridge_losses  <= ssfd_pkg::RST_BRIDGE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        ssfd_pkg::REG_NUM_POINTS:  num_points     <= pwdata[8:0];
        ssfd_pkg::REG_SUB_STEPS:   sub_steps      <= pwdata[4:0];
        ssfd_pkg::REG_PITCH_RATE:  pitch_rate     <= pwdata[17:0];
        ssfd_pkg::REG_STIFFNESS:   stiffness_coef <= pwdata[16:0];
        ssfd_pkg::REG_DAMPING:     damping_coef   <= pwdata[18:0];
        ssfd_pkg::REG_PALM_CENTER: palm_center    <= pwdata[7:0];
        ssfd_pkg::REG_PALM_LOSS:   palm_loss      <= pwdata[11:0];
        ssfd_pkg::REG_BRIDGE:      bridge_losses  <= pwdata[35:0];
      endcase
    end
  end

  // register read port
  always_comb begin
    unique case (paddr[5:3])
      ssfd_pkg::REG_NUM_POINTS:  prdata = 64'(num_points);
      ssfd_pkg::REG_SUB_STEPS:   prdata = 64'(sub_steps);
      ssfd_pkg::REG_PITCH_RATE:  prdata = 64'(pitch_rate);
      ssfd_pkg::REG_STIFFNESS:   prdata = 64'(stiffness_coef);
      ssfd_pkg::REG_DAMPING:     prdata = 64'(damping_coef);
      ssfd_pkg::REG_PALM_CENTER: prdata = 64'(palm_center);
      ssfd_pkg::REG_PALM_LOSS:   prdata = 64'(palm_loss);
      ssfd_pkg::REG_BRIDGE:      prdata = 64'(bridge_losses);
    endcase
  end

  // saturated register views
  always_comb begin
    if (32'(num_points) < ssfd_pkg::N_MIN) begin
      n_eff = NW'(ssfd_pkg::N_MIN);
    end else if (32'(num_points) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(num_points);
    end
    if (sub_steps == 5'd0) begin
      steps = 5'd1;
    end else if (32'(sub_steps) > ssfd_pkg::STEPS_MAX) begin
      steps = 5'(ssfd_pkg::STEPS_MAX);
    end else begin
      steps = sub_steps;
    end
    if (32'(pitch_rate) < ssfd_pkg::RATE_MIN) begin
      rate = 18'(ssfd_pkg::RATE_MIN);
    end else if (32'(pitch_rate) > ssfd_pkg::RATE_MAX) begin
      rate = 18'(ssfd_pkg::RATE_MAX);
    end else begin
      rate = pitch_rate;
    end
    stiff   = (32'(stiffness_coef) > ssfd_pkg::STIFF_MAX) ?
              17'(ssfd_pkg::STIFF_MAX) : stiffness_coef;
    damp    = (32'(damping_coef) > ssfd_pkg::DAMP_MAX) ?
              19'(ssfd_pkg::DAMP_MAX) : damping_coef;
    loss_pk = (32'(palm_loss) > ssfd_pkg::PALM_MAX) ?
              12'(ssfd_pkg::PALM_MAX) : palm_loss;
    w_len   = WW'((32'(n_eff) * ssfd_pkg::W_RECIP) >> ssfd_pkg::W_RECIP_SH);
    n_m2    = XW'(n_eff) - XW'(2);
    n_m3    = XW'(n_eff) - XW'(3);
    if (palm_center == 8'd0) begin
      palm_c = XW'(1);
    end else if (32'(palm_center) > 32'(n_m2)) begin
      palm_c = n_m2;
    end else begin
      palm_c = XW'(palm_center);
    end
    if (pick == 8'd0) begin
      pick_c = XW'(1);
    end else if (32'(pick) > 32'(n_m2)) begin
      pick_c = n_m2;
    end else begin
      pick_c = XW'(pick);
    end
  end

  // per-point conditions
  always_comb begin
    pt_dist  = (i_idx > palm_c) ? (i_idx - palm_c) : (palm_c - i_idx);
    in_palm  = (loss_pk != 12'd0) && (pt_dist <= XW'(w_len));
    bend_on  = (i_idx >= XW'(2)) && (i_idx <= n_m3);
    br_edge  = (i_idx == XW'(1)) || (i_idx == n_m2);
    br_inner = (i_idx == XW'(2)) || (i_idx == n_m3);
    br_hit   = br_edge || br_inner;
    wr_ok    = (32'(point_index) < MAX_POINTS);
  end

  // tension and bend stencils over the window
  always_comb begin
    tension = AW'(wp[1]) - 2 * AW'(wp[2]) + AW'(wp[3]);
    bend    = AW'(wp[0]) - 4 * AW'(wp[1]) + 6 * AW'(wp[2]) - 4 * AW'(wp[3]) + AW'(wp[4]);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = acc;
    mul_b = '0;
    unique case (state)
      ST_M_STIFF:                mul_b = CW'(stiff);
      ST_M_RATE_F, ST_M_RATE_V:  mul_b = CW'(rate);
      ST_M_DAMP:                 mul_b = damp;
      ST_M_LOSS: begin
        mul_a = AW'(XW'(w_len) - pt_dist);
        mul_b = CW'(loss_pk);
      end
      ST_M_PALM:   mul_b = CW'(ssfd_pkg::ONE_Q18) - CW'(dnum[ssfd_pkg::LOSS_W-1:0]);
      ST_M_BRIDGE: mul_b = br_edge ? CW'(bridge_losses[17:0]) : CW'(bridge_losses[35:18]);
      default: ;
    endcase
  end

  // product rounding, ties toward plus infinity
  always_comb begin
    prod_sum = prod + RND_HALF;
    prod_rnd = AW'(prod_sum >>> ssfd_pkg::Q_SHIFT);
  end

  // restoring divider step for the palm loss
  always_comb begin
    den      = {w_len, 1'b0};
    trial    = {drem, dnum[NUMW-1]};
    q_bit    = (trial >= {1'b0, den});
    rem_next = q_bit ? DW'(trial - {1'b0, den}) : DW'(trial);
  end

  // memory port control
  always_comb begin
    pos_we    = 1'b0;
    vel_we    = 1'b0;
    pos_re    = 1'b0;
    vel_re    = 1'b0;
    pos_waddr = '0;
    vel_waddr = '0;
    pos_raddr = '0;
    vel_raddr = '0;
    pos_wdata = '0;
    vel_wdata = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (mode == ssfd_pkg::MODE_WRITE) && wr_ok) begin
          pos_we    = 1'b1;
          pos_waddr = IW'(point_index);
          pos_wdata = ssfd_pkg::clamp_val(AW'(point_value));
        end
      end
      ST_CLEAR: begin
        pos_we    = 1'b1;
        vel_we    = 1'b1;
        pos_waddr = IW'(cnt);
        vel_waddr = IW'(cnt);
      end
      ST_PRE: begin
        pos_re    = (cnt < NW'(4));
        pos_raddr = IW'(cnt);
      end
      ST_LOAD: begin
        pos_re    = 1'b1;
        pos_raddr = IW'(i_idx + XW'(3));
        vel_re    = 1'b1;
        vel_raddr = IW'(i_idx);
      end
      ST_WRITE: begin
        pos_we    = 1'b1;
        vel_we    = 1'b1;
        pos_waddr = IW'(i_idx);
        vel_waddr = IW'(i_idx);
        pos_wdata = ssfd_pkg::clamp_val(pnew);
        vel_wdata = ssfd_pkg::clamp_val(acc);
      end
      ST_ENDS: begin
        pos_we    = 1'b1;
        vel_we    = 1'b1;
        pos_waddr = (cnt == '0) ? '0 : IW'(n_eff - NW'(1));
        vel_waddr = pos_waddr;
      end
      ST_PICK: begin
        pos_re = (cnt < NW'(3));
        if (cnt == '0) begin
          pos_raddr = IW'(pick_c - XW'(1));
        end else if (cnt == NW'(1)) begin
          pos_raddr = IW'(pick_c);
        end else begin
          pos_raddr = IW'(pick_c + XW'(1));
        end
      end
      default: ;
    endcase
  end

  // displacement store
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pos_re) begin
      pos_rd <= pos_mem[pos_raddr];
    end
  end

  // velocity store
  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_mem[vel_waddr] <= vel_wdata;
    end
    if (vel_re) begin
      vel_rd <= vel_mem[vel_raddr];
    end
  end

  // shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, mul_b});
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // the result state sets out_valid itself
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (mode)
              ssfd_pkg::MODE_TICK: begin
                pick  <= pickup_point;
                step  <= '0;
                cnt   <= '0;
                state <= ST_PRE;
              end
              ssfd_pkg::MODE_CLEAR: begin
                cnt   <= '0;
                state <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + NW'(1);
          if (cnt == NW'(MAX_POINTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_PRE: begin
          cnt <= cnt + NW'(1);
          if (cnt != '0) begin
            wp[0] <= wp[1];
            wp[1] <= wp[2];
            wp[2] <= wp[3];
            wp[3] <= wp[4];
            wp[4] <= pos_rd;
          end
          if (cnt == NW'(4)) begin
            i_idx <= XW'(1);
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          acc   <= bend;
          state <= ST_M_STIFF;
        end
        ST_M_STIFF: state <= ST_A_STIFF;
        ST_A_STIFF: begin
          acc   <= bend_on ? (tension - prod_rnd) : tension;
          state <= ST_M_RATE_F;
        end
        ST_M_RATE_F: state <= ST_A_RATE_F;
        ST_A_RATE_F: begin
          acc   <= AW'(vel_rd) + prod_rnd;
          state <= ST_M_DAMP;
        end
        ST_M_DAMP: state <= ST_A_DAMP;
        ST_A_DAMP: begin
          acc   <= prod_rnd;
          state <= ST_M_RATE_V;
        end
        ST_M_RATE_V: state <= ST_A_RATE_V;
        ST_A_RATE_V: begin
          pnew <= AW'(wp[2]) + prod_rnd;
          if (in_palm) begin
            state <= ST_M_LOSS;
          end else if (br_hit) begin
            state <= ST_M_BRIDGE;
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_M_LOSS: state <= ST_D_INIT;
        ST_D_INIT: begin
          dnum  <= {prod[NUMW-2:0], 1'b0} + NUMW'(w_len);
          drem  <= '0;
          dcnt  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          dnum <= {dnum[NUMW-2:0], q_bit};
          drem <= rem_next;
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(NUMW - 1)) begin
            state <= ST_M_PALM;
          end
        end
        ST_M_PALM: state <= ST_A_PALM;
        ST_A_PALM: begin
          acc   <= prod_rnd;
          state <= br_hit ? ST_M_BRIDGE : ST_WRITE;
        end
        ST_M_BRIDGE: state <= ST_A_BRIDGE;
        ST_A_BRIDGE: begin
          acc   <= prod_rnd;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          wp[0] <= wp[1];
          wp[1] <= wp[2];
          wp[2] <= wp[3];
          wp[3] <= wp[4];
          wp[4] <= pos_rd;
          if (i_idx == n_m2) begin
            cnt   <= '0;
            state <= ST_ENDS;
          end else begin
            i_idx <= i_idx + XW'(1);
            state <= ST_LOAD;
          end
        end
        ST_ENDS: begin
          if (cnt == NW'(1)) begin
            cnt <= '0;
            if (step == steps - 5'd1) begin
              state <= ST_PICK;
            end else begin
              step  <= step + 5'd1;
              state <= ST_PRE;
            end
          end else begin
            cnt <= cnt + NW'(1);
          end
        end
        ST_PICK: begin
          cnt <= cnt + NW'(1);
          if (cnt == NW'(1)) begin
            sum <= (AW + 2)'(pos_rd);
          end else if (cnt == NW'(2)) begin
            sum <= sum + 2 * (AW + 2)'(pos_rd);
          end else if (cnt == NW'(3)) begin
            sum   <= sum + (AW + 2)'(pos_rd);
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            sample    <= ssfd_pkg::SAMPLE_W'((sum + (AW + 2)'(1)) >>> 1);
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (mode == ssfd_pkg::MODE_TICK)) |=> in_stall)
    else $error("tick transaction did not start the update sequence");

  a_sample_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("sample raised outside the result state");

  a_update_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> ((i_idx >= XW'(1)) && (i_idx <= n_m2)))
    else $error("update write outside the interior points");
`endif

endmodule

>>> bench/ssfd_string_checker.sv
// transaction checker and string predictor for the stiff string step unit
module ssfd_string_checker
  import ssfd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [5:0]                 paddr,
  input  logic [63:0]                pwdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [7:0]                 point_index,
  input  logic signed [VAL_W-1:0]    point_value,
  input  logic [7:0]                 pickup_point,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output int                         mismatches,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies, raw as written
  logic [8:0]  r_points;
  logic [4:0]  r_steps;
  logic [17:0] r_rate;
  logic [16:0] r_stiff;
  logic [18:0] r_damp;
  logic [7:0]  r_palm_c;
  logic [11:0] r_palm_loss;
  logic [35:0] r_bridge;

  // string state
  logic signed [VAL_W-1:0] disp_mem [MAX_POINTS_DEF];
  logic signed [VAL_W-1:0] vel_mem  [MAX_POINTS_DEF];
  longint next_pos [MAX_POINTS_DEF];
  longint next_vel [MAX_POINTS_DEF];

  logic [SAMPLE_W-1:0] sample_q [$];
  int results_seen;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // coefficient product, rounded half up
  function automatic longint mulq(longint a, longint b);
    return (a * b + 131072) >>> Q_SHIFT;
  endfunction

  function automatic longint live_points();
    return sat(longint'(r_points), N_MIN, MAX_POINTS_DEF);
  endfunction

  // one finite-difference update of the whole string
  task automatic advance_string();
    longint n, rate, stiff, damp, loss_pk, edge_f, inner_f;
    longint net_force, bend, v, w, c, lo, hi, d, loss;
    n       = live_points();
    rate    = sat(longint'(r_rate), RATE_MIN, RATE_MAX);
    stiff   = sat(longint'(r_stiff), 0, STIFF_MAX);
    damp    = sat(longint'(r_damp), 0, DAMP_MAX);
    loss_pk = sat(longint'(r_palm_loss), 0, PALM_MAX);
    edge_f  = longint'(r_bridge[17:0]);
    inner_f = longint'(r_bridge[35:18]);
    for (int i = 1; i < n - 1; i++) begin
      net_force = longint'(disp_mem[i-1]) - 2 * longint'(disp_mem[i])
                + longint'(disp_mem[i+1]);
      if (i > 1 && i + 2 < n) begin
        bend = longint'(disp_mem[i-2]) - 4 * longint'(disp_mem[i-1])
             + 6 * longint'(disp_mem[i]) - 4 * longint'(disp_mem[i+1])
             + longint'(disp_mem[i+2]);
        net_force -= mulq(stiff, bend);
      end
      v = mulq(longint'(vel_mem[i]) + mulq(rate, net_force), damp);
      next_vel[i] = v;
      next_pos[i] = longint'(disp_mem[i]) + mulq(rate, v);
    end
    next_pos[0] = 0; next_vel[0] = 0;
    next_pos[n-1] = 0; next_vel[n-1] = 0;
    // palm muting window, triangular loss around the center
    if (loss_pk != 0) begin
      w  = n / 10;
      c  = sat(longint'(r_palm_c), 1, n - 2);
      lo = (c - w < 1) ? 1 : c - w;
      hi = (c + w > n - 2) ? n - 2 : c + w;
      for (longint k = lo; k <= hi; k++) begin
        d = (k > c) ? k - c : c - k;
        loss = (loss_pk * (w - d) * 2 + w) / (2 * w);
        next_vel[k] = mulq(next_vel[k], ONE_Q18 - loss);
      end
    end
    // bridge losses on the two points next to each end
    next_vel[1]   = mulq(next_vel[1], edge_f);
    next_vel[n-2] = mulq(next_vel[n-2], edge_f);
    next_vel[2]   = mulq(next_vel[2], inner_f);
    next_vel[n-3] = mulq(next_vel[n-3], inner_f);
    for (int i = 0; i < n; i++) begin
      disp_mem[i] = VAL_W'(sat(next_pos[i], -VAL_LIM, VAL_LIM));
      vel_mem[i]  = VAL_W'(sat(next_vel[i], -VAL_LIM, VAL_LIM));
    end
  endtask

  // pickup sum after a tick
  function automatic logic [SAMPLE_W-1:0] pickup_sum(logic [7:0] pick);
    longint n, c, sum;
    n = live_points();
    c = sat(longint'(pick), 1, n - 2);
    sum = 2 * longint'(disp_mem[c]) + longint'(disp_mem[c-1]) + longint'(disp_mem[c+1]);
    return SAMPLE_W'((sum + 1) >>> 1);
  endfunction

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    longint steps;
    if (rst) begin
      r_points    = RST_NUM_POINTS;
      r_steps     = RST_SUB_STEPS;
      r_rate      = RST_PITCH_RATE;
      r_stiff     = RST_STIFFNESS;
      r_damp      = RST_DAMPING;
      r_palm_c    = RST_PALM_CENTER;
      r_palm_loss = RST_PALM_LOSS;
      r_bridge    = RST_BRIDGE;
      for (int i = 0; i < MAX_POINTS_DEF; i++) begin
        disp_mem[i] = '0;
        vel_mem[i]  = '0;
      end
      sample_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_NUM_POINTS:  r_points    = pwdata[8:0];
          REG_SUB_STEPS:   r_steps     = pwdata[4:0];
          REG_PITCH_RATE:  r_rate      = pwdata[17:0];
          REG_STIFFNESS:   r_stiff     = pwdata[16:0];
          REG_DAMPING:     r_damp      = pwdata[18:0];
          REG_PALM_CENTER: r_palm_c    = pwdata[7:0];
          REG_PALM_LOSS:   r_palm_loss = pwdata[11:0];
          REG_BRIDGE:      r_bridge    = pwdata[35:0];
          default: ;
        endcase
      end
      // sample transaction, checked before this edge's input
      if (out_valid && !out_stall) begin
        results_seen++;
        if (sample_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: unexpected sample %0d", sample);
        end else begin
          want = sample_q.pop_front();
          if (want !== sample) begin
            mismatches++;
            if (mismatches <= 10)
              $display("checker: sample %0d expected %0d got %0d", results_seen,
                       $signed(want), sample);
          end
        end
      end
      // input transaction
      if (in_valid && !in_stall) begin
        case (mode)
          MODE_TICK: begin
            steps = sat(longint'(r_steps), 1, STEPS_MAX);
            for (longint s = 0; s < steps; s++) advance_string();
            sample_q = {sample_q, pickup_sum(pickup_point)};
          end
          MODE_WRITE: begin
            disp_mem[point_index] = VAL_W'(sat(longint'(point_value), -VAL_LIM, VAL_LIM));
          end
          MODE_CLEAR: begin
            for (int i = 0; i < MAX_POINTS_DEF; i++) begin
              disp_mem[i] = '0;
              vel_mem[i]  = '0;
            end
          end
          default: ;
        endcase
      end
    end
    outstanding = sample_q.size();
  end

endmodule

>>> bench/tb.sv
// testbench top for the stiff string step unit: stimulus, stalls and verdict
module tb;
  import ssfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_TICK;
  logic [7:0] point_index = '0;
  logic signed [VAL_W-1:0] point_value = '0;
  logic [7:0] pickup_point = 8'd1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;

  int mismatches, outstanding;
  int cyc = 0;
  int n_ticks = 0, n_writes = 0, n_clears = 0, n_cfg = 0, n_phases = 0;

  stiff_string_fd_step_unit u_dut (.*);

  ssfd_string_checker u_chk (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .mode, .point_index, .point_value, .pickup_point,
    .out_valid, .out_stall, .sample, .mismatches, .outstanding
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver stall pattern: free, random, then periodic bursts
  always @(negedge clk) begin
    case ((cyc / 1500) % 3)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 99) < 40);
      default: out_stall = ((cyc % 37) < 20);
    endcase
  end

  // register write, setup then access
  task automatic reg_write(logic [2:0] idx, logic [63:0] data);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000}; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    n_cfg++;
  endtask

  // one input transaction, held until accepted
  task automatic push(logic [1:0] m, logic [7:0] idx, logic [VAL_W-1:0] val, logic [7:0] pick);
    @(negedge clk);
    in_valid = 1'b1; mode = m; point_index = idx; point_value = val; pickup_point = pick;
    do @(posedge clk); while (in_stall);
    case (m)
      MODE_TICK:  n_ticks++;
      MODE_WRITE: n_writes++;
      MODE_CLEAR: n_clears++;
      default: ;
    endcase
  endtask

  task automatic idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // wait until every sample is back, then let a clear or write finish
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    idle(300);
  endtask

  task automatic configure(logic [63:0] pts, logic [63:0] steps, logic [63:0] rate,
                           logic [63:0] stiff, logic [63:0] damp, logic [63:0] pc,
                           logic [63:0] pl, logic [63:0] br);
    drain();
    reg_write(REG_NUM_POINTS, pts);
    reg_write(REG_SUB_STEPS, steps);
    reg_write(REG_PITCH_RATE, rate);
    reg_write(REG_STIFFNESS, stiff);
    reg_write(REG_DAMPING, damp);
    reg_write(REG_PALM_CENTER, pc);
    reg_write(REG_PALM_LOSS, pl);
    reg_write(REG_BRIDGE, br);
    n_phases++;
  endtask

  // random traffic: mostly plucks followed by ticks, some noise
  task automatic random_traffic(int count, int n);
    int done, burst, k;
    done = 0;
    burst = $urandom_range(1, 8);
    while (done < count) begin
      if ($urandom_range(0, 99) < 70) begin
        k = $urandom_range(2, 6);
        repeat (k) begin
          push(MODE_WRITE, 8'($urandom_range(0, n - 1)),
               VAL_W'($signed($urandom_range(0, 2 * VAL_LIM)) - VAL_LIM),
               8'($urandom));
          done++;
        end
        k = $urandom_range(1, 4);
        repeat (k) begin
          push(MODE_TICK, 8'($urandom), VAL_W'($urandom), 8'($urandom_range(0, 255)));
          done++;
        end
      end else begin
        case ($urandom_range(0, 5))
          0, 1: push(MODE_TICK, 8'($urandom), VAL_W'($urandom), 8'($urandom));
          2, 3: push(MODE_WRITE, 8'($urandom), VAL_W'($urandom), 8'($urandom));
          4: push(MODE_CLEAR, 8'($urandom), VAL_W'($urandom), 8'($urandom));
          default: push(2'd3, 8'($urandom), VAL_W'($urandom), 8'($urandom));
        endcase
        done++;
      end
      // sender bursts and gaps
      burst--;
      if (burst <= 0) begin
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
        burst = $urandom_range(1, 10);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items on reset settings
    push(MODE_WRITE, 8'd5, VAL_W'(VAL_LIM), 8'd0);
    push(MODE_WRITE, 8'd6, VAL_W'(-VAL_LIM), 8'd0);
    push(MODE_WRITE, 8'd0, 23'h3F_FFFF, 8'd0);
    push(MODE_WRITE, 8'd15, 23'h40_0000, 8'd0);
    push(MODE_WRITE, 8'd255, 23'h40_0000, 8'd0);
    push(MODE_TICK, 8'd0, '0, 8'd0);
    push(MODE_TICK, 8'd0, '0, 8'd255);
    push(MODE_TICK, 8'd0, '0, 8'd5);
    push(2'd3, 8'd7, 23'h2A_AAAA, 8'd7);
    push(MODE_WRITE, 8'd7, VAL_W'(VAL_LIM), 8'd0);
    push(MODE_WRITE, 8'd8, VAL_W'(VAL_LIM), 8'd0);
    push(MODE_TICK, 8'd0, '0, 8'd7);
    push(MODE_TICK, 8'd0, '0, 8'd14);
    push(MODE_CLEAR, 8'hFF, 23'h7F_FFFF, 8'hFF);
    push(MODE_TICK, 8'd0, '0, 8'd1);
    push(MODE_WRITE, 8'd3, 23'h15_5555, 8'd0);
    push(MODE_TICK, 8'd0, '0, 8'd3);

    // small string, fastest rate, full stiffness and palm
    configure(16, 1, RATE_MAX, STIFF_MAX, DAMP_MAX, 1, PALM_MAX, 64'hF_FFFF_FFFF);
    random_traffic(25, 16);

    configure(24, 3, 100000, 30000, 250000, 12, 1500, {18'd200000, 18'd240000});
    random_traffic(25, 24);

    // every register but the bridge losses out of range, saturating
    configure(0, 0, 0, 17'h1FFFF, 19'h7FFFF, 255, 12'hFFF, 0);
    random_traffic(20, 16);

    configure(40, 5, RATE_MAX, 0, 0, 20, 1, {28'h0, $urandom});
    random_traffic(25, 40);

    configure(17, 31, $urandom_range(RATE_MIN, RATE_MAX), $urandom_range(0, STIFF_MAX),
              $urandom_range(200000, DAMP_MAX), $urandom_range(1, 15),
              $urandom_range(0, PALM_MAX), {$urandom, $urandom});
    random_traffic(15, 17);

    // longest string, most updates per tick
    configure(511, 16, 150000, STIFF_MAX, 262000, 128, PALM_MAX, 64'hF_FFFF_FFFF);
    push(MODE_WRITE, 8'd100, VAL_W'(VAL_LIM), 8'd0);
    push(MODE_WRITE, 8'd101, VAL_W'(VAL_LIM / 2), 8'd0);
    push(MODE_WRITE, 8'd254, VAL_W'(-VAL_LIM), 8'd0);
    push(MODE_TICK, 8'd0, '0, 8'd100);
    push(MODE_TICK, 8'd0, '0, 8'd254);

    drain();
    $display("covered %0d phases, %0d register writes, %0d ticks, %0d point writes, %0d clears",
             n_phases, n_cfg, n_ticks, n_writes, n_clears);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d sample mismatches", mismatches);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
